### rtl/core/stereo_linked_noise_gate_macros.svh
// ----------------------------------------------------------------------------
// Stereo linked noise gate assertion macros
// Shared assertion forms for the noise gate checks.
// ----------------------------------------------------------------------------
`ifndef STEREO_LINKED_NOISE_GATE_MACROS_SVH
`define STEREO_LINKED_NOISE_GATE_MACROS_SVH

// A check that is switched off while reset is asserted.
`define SNG_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A check that also covers the reset cycles.
`define SNG_CHECK_RESET(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/sng_pkg.sv
// ----------------------------------------------------------------------------
// Stereo linked noise gate package
// Default widths, register indexes, reset values and sequencer states.
// ----------------------------------------------------------------------------
package sng_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int COEF_BITS_DEF   = 16;

  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam int QUEUE_DEPTH = 2;

  // Reset values, given for 16 step bits and 24 sample bits.
  localparam int REF_COEF_BITS    = 16;
  localparam int REF_SAMPLE_BITS  = 24;
  localparam int ATTACK_STEP_RST  = 1350;
  localparam int RELEASE_STEP_RST = 27;
  localparam int OPEN_THRESH_RST  = 83886;
  localparam int CLOSE_THRESH_RST = 59388;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ATTACK_STEP  = 8'd0,
    REG_RELEASE_STEP = 8'd1,
    REG_OPEN_THRESH  = 8'd2,
    REG_CLOSE_THRESH = 8'd3
  } cfg_reg_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_ENV,
    BK_GATE,
    BK_GAIN,
    BK_GUPD,
    BK_LEFT,
    BK_RIGHT,
    BK_FIN
  } bk_state_t;

endpackage

### rtl/core/sng_channels.sv
// ----------------------------------------------------------------------------
// Stereo linked noise gate channels
// Valid/ready interfaces for samples, results and register writes.
// ----------------------------------------------------------------------------
interface sng_in_if #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_in;
  logic signed [SAMPLE_BITS-1:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface sng_out_if #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = sng_pkg::COEF_BITS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_out;
  logic signed [SAMPLE_BITS-1:0] right_out;
  logic                          is_open;
  logic [COEF_BITS:0]            applied_gain;

  modport source (output valid, output left_out, output right_out, output is_open,
                  output applied_gain, input ready);
  modport sink   (input valid, input left_out, input right_out, input is_open,
                  input applied_gain, output ready);
endinterface

interface sng_cfg_if ();
  import sng_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/sng_front.sv
// ----------------------------------------------------------------------------
// Stereo linked noise gate front end
// Accepts sample pairs and forms the larger of the two magnitudes.
// ----------------------------------------------------------------------------
module sng_front #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS_DEF
) (
  sng_in_if.sink                  in_ch,
  output logic                    push_valid,
  input  logic                    push_ready,
  output logic signed [SAMPLE_BITS-1:0] push_left,
  output logic signed [SAMPLE_BITS-1:0] push_right,
  output logic [SAMPLE_BITS-1:0]  push_mag
);
  import sng_pkg::*;

  logic signed [SAMPLE_BITS:0] left_x;
  logic signed [SAMPLE_BITS:0] right_x;
  logic signed [SAMPLE_BITS:0] left_abs;
  logic signed [SAMPLE_BITS:0] right_abs;
  logic [SAMPLE_BITS-1:0]      left_mag;
  logic [SAMPLE_BITS-1:0]      right_mag;

  always_comb begin
    left_x    = {in_ch.left_in[SAMPLE_BITS-1], in_ch.left_in};
    right_x   = {in_ch.right_in[SAMPLE_BITS-1], in_ch.right_in};
    left_abs  = left_x[SAMPLE_BITS] ? -left_x : left_x;
    right_abs = right_x[SAMPLE_BITS] ? -right_x : right_x;
    left_mag  = left_abs[SAMPLE_BITS-1:0];
    right_mag = right_abs[SAMPLE_BITS-1:0];
  end

  assign push_valid  = in_ch.valid;
  assign in_ch.ready = push_ready;
  assign push_left   = in_ch.left_in;
  assign push_right  = in_ch.right_in;
  assign push_mag    = (left_mag > right_mag) ? left_mag : right_mag;

endmodule

### rtl/core/sng_queue.sv
// ----------------------------------------------------------------------------
// Stereo linked noise gate queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module sng_queue #(
  parameter int WIDTH = 3 * sng_pkg::SAMPLE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  output logic             s_ready,
  input  logic [WIDTH-1:0] s_data,
  output logic             m_valid,
  input  logic             m_ready,
  output logic [WIDTH-1:0] m_data
);
  import sng_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(QUEUE_DEPTH);

  logic [WIDTH-1:0]    slot_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr_r;
  logic [PTR_BITS-1:0] wr_ptr_nxt;
  logic [PTR_BITS-1:0] rd_ptr_r;
  logic [PTR_BITS-1:0] rd_ptr_nxt;
  logic [CNT_BITS-1:0] count_r;
  logic [CNT_BITS-1:0] count_nxt;
  logic                push;
  logic                pop;

  assign s_ready = (count_r != CNT_FULL);
  assign m_valid = (count_r != '0);
  assign m_data  = slot_r[rd_ptr_r];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= s_data;
    end
  end

endmodule

### rtl/core/sng_back.sv
// ----------------------------------------------------------------------------
// Stereo linked noise gate back end
// Envelope, gate and gain sequencer around one shared multiplier, with the
// configuration registers and the result register.
// ----------------------------------------------------------------------------
module sng_back #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = sng_pkg::COEF_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  logic signed [SAMPLE_BITS-1:0] q_left,
  input  logic signed [SAMPLE_BITS-1:0] q_right,
  input  logic [SAMPLE_BITS-1:0]        q_mag,
  sng_cfg_if.sink                       cfg_ch,
  sng_out_if.source                     out_ch
);
  import sng_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int CB = COEF_BITS;
  localparam int AW = (SB + 1 > CB + 2) ? SB + 1 : CB + 2;
  localparam int PW = AW + CB + 2;
  localparam int RW = PW - CB;

  localparam logic [CB:0] GAIN_ONE = {1'b1, {CB{1'b0}}};
  localparam logic signed [PW-1:0] HALF = {{(PW-CB){1'b0}}, 1'b1, {(CB-1){1'b0}}};
  localparam logic signed [PW-1:0] HALF_M1 = {{(PW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [RW-1:0] SMAX_W = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [RW-1:0] SMIN_W = {{(RW-SB+1){1'b1}}, {(SB-1){1'b0}}};

  localparam logic [CB-1:0] ATK_RST = (CB >= REF_COEF_BITS) ?
    CB'(ATTACK_STEP_RST << (CB - REF_COEF_BITS)) :
    CB'(ATTACK_STEP_RST >> (REF_COEF_BITS - CB));
  localparam logic [CB-1:0] REL_RST = (CB >= REF_COEF_BITS) ?
    CB'(RELEASE_STEP_RST << (CB - REF_COEF_BITS)) :
    CB'(RELEASE_STEP_RST >> (REF_COEF_BITS - CB));
  localparam logic [SB-1:0] OPN_RST = (SB >= REF_SAMPLE_BITS) ?
    SB'(OPEN_THRESH_RST << (SB - REF_SAMPLE_BITS)) :
    SB'(OPEN_THRESH_RST >> (REF_SAMPLE_BITS - SB));
  localparam logic [SB-1:0] CLS_RST = (SB >= REF_SAMPLE_BITS) ?
    SB'(CLOSE_THRESH_RST << (SB - REF_SAMPLE_BITS)) :
    SB'(CLOSE_THRESH_RST >> (REF_SAMPLE_BITS - SB));

  // Round to nearest after dropping the step fraction, halves away from zero.
  function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    s = p + (p[PW-1] ? HALF_M1 : HALF);
    return s[PW-1:CB];
  endfunction

  function automatic logic signed [SB-1:0] sat(input logic signed [RW-1:0] v);
    logic signed [SB-1:0] res;
    if (v > SMAX_W) begin
      res = SMAX_W[SB-1:0];
    end else if (v < SMIN_W) begin
      res = SMIN_W[SB-1:0];
    end else begin
      res = v[SB-1:0];
    end
    return res;
  endfunction

  bk_state_t st_r;
  bk_state_t st_nxt;

  logic [CB-1:0]        atk_r, atk_nxt;
  logic [CB-1:0]        rel_r, rel_nxt;
  logic [SB-1:0]        opn_r, opn_nxt;
  logic [SB-1:0]        cls_r, cls_nxt;
  logic [SB-1:0]        env_r, env_nxt;
  logic                 gate_r, gate_nxt;
  logic [CB:0]          gain_r, gain_nxt;
  logic                 ov_r, ov_nxt;

  logic signed [SB-1:0] l_r, l_nxt;
  logic signed [SB-1:0] r_r, r_nxt;
  logic [SB-1:0]        m_r, m_nxt;
  logic signed [PW-1:0] prod_r, prod_nxt;
  logic signed [SB-1:0] lo_r, lo_nxt;
  logic signed [SB-1:0] olo_r, olo_nxt;
  logic signed [SB-1:0] oro_r, oro_nxt;
  logic                 oopen_r, oopen_nxt;
  logic [CB:0]          ogain_r, ogain_nxt;

  logic signed [AW-1:0] mul_a;
  logic [CB:0]          mul_b;
  logic signed [RW-1:0] rnd_v;
  logic signed [RW-1:0] env_sum;
  logic signed [RW-1:0] gain_sum;
  logic [SB-1:0]        env_new;

  always_comb begin
    st_nxt    = st_r;
    atk_nxt   = atk_r;
    rel_nxt   = rel_r;
    opn_nxt   = opn_r;
    cls_nxt   = cls_r;
    env_nxt   = env_r;
    gate_nxt  = gate_r;
    gain_nxt  = gain_r;
    ov_nxt    = ov_r;
    l_nxt     = l_r;
    r_nxt     = r_r;
    m_nxt     = m_r;
    lo_nxt    = lo_r;
    olo_nxt   = olo_r;
    oro_nxt   = oro_r;
    oopen_nxt = oopen_r;
    ogain_nxt = ogain_r;
    q_ready   = 1'b0;
    mul_a     = '0;
    mul_b     = '0;

    rnd_v    = rnd(prod_r);
    env_sum  = RW'($signed({1'b0, env_r})) + rnd_v;
    gain_sum = RW'($signed({1'b0, gain_r})) + rnd_v;
    env_new  = env_sum[SB-1:0];

    if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_ATTACK_STEP:  atk_nxt = cfg_ch.data[CB-1:0];
        REG_RELEASE_STEP: rel_nxt = cfg_ch.data[CB-1:0];
        REG_OPEN_THRESH:  opn_nxt = cfg_ch.data[SB-1:0];
        REG_CLOSE_THRESH: cls_nxt = cfg_ch.data[SB-1:0];
        default: ;
      endcase
    end

    if (ov_r && out_ch.ready) begin
      ov_nxt = 1'b0;
    end

    case (st_r)
      BK_IDLE: begin
        if (q_valid) begin
          q_ready = 1'b1;
          st_nxt  = BK_ENV;
        end
      end
      BK_ENV: begin
        mul_a  = AW'($signed({1'b0, m_r})) - AW'($signed({1'b0, env_r}));
        mul_b  = (m_r > env_r) ? {1'b0, atk_r} : {1'b0, rel_r};
        st_nxt = BK_GATE;
      end
      BK_GATE: begin
        env_nxt = env_new;
        if (gate_r) begin
          if (env_new < cls_r) begin
            gate_nxt = 1'b0;
          end
        end else if (env_new > opn_r) begin
          gate_nxt = 1'b1;
        end
        st_nxt = BK_GAIN;
      end
      BK_GAIN: begin
        if (gate_r) begin
          mul_a = AW'($signed({1'b0, GAIN_ONE})) - AW'($signed({1'b0, gain_r}));
          mul_b = {1'b0, atk_r};
        end else begin
          mul_a = -AW'($signed({1'b0, gain_r}));
          mul_b = {1'b0, rel_r};
        end
        st_nxt = BK_GUPD;
      end
      BK_GUPD: begin
        gain_nxt = gain_sum[CB:0];
        st_nxt   = BK_LEFT;
      end
      BK_LEFT: begin
        mul_a  = AW'(l_r);
        mul_b  = gain_r;
        st_nxt = BK_RIGHT;
      end
      BK_RIGHT: begin
        lo_nxt = sat(rnd_v);
        mul_a  = AW'(r_r);
        mul_b  = gain_r;
        st_nxt = BK_FIN;
      end
      BK_FIN: begin
        // The right product is formed again each cycle so that it survives a stall.
        mul_a = AW'(r_r);
        mul_b = gain_r;
        if (!ov_r || out_ch.ready) begin
          ov_nxt    = 1'b1;
          olo_nxt   = lo_r;
          oro_nxt   = sat(rnd_v);
          oopen_nxt = gate_r;
          ogain_nxt = gain_r;
          if (q_valid) begin
            q_ready = 1'b1;
            st_nxt  = BK_ENV;
          end else begin
            st_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        st_nxt = BK_IDLE;
      end
    endcase

    if (q_ready) begin
      l_nxt = q_left;
      r_nxt = q_right;
      m_nxt = q_mag;
    end

    prod_nxt = PW'(mul_a) * PW'($signed({1'b0, mul_b}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BK_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      atk_r  <= ATK_RST;
      rel_r  <= REL_RST;
      opn_r  <= OPN_RST;
      cls_r  <= CLS_RST;
      env_r  <= '0;
      gate_r <= 1'b1;
      gain_r <= GAIN_ONE;
      ov_r   <= 1'b0;
    end else begin
      atk_r  <= atk_nxt;
      rel_r  <= rel_nxt;
      opn_r  <= opn_nxt;
      cls_r  <= cls_nxt;
      env_r  <= env_nxt;
      gate_r <= gate_nxt;
      gain_r <= gain_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    l_r     <= l_nxt;
    r_r     <= r_nxt;
    m_r     <= m_nxt;
    prod_r  <= prod_nxt;
    lo_r    <= lo_nxt;
    olo_r   <= olo_nxt;
    oro_r   <= oro_nxt;
    oopen_r <= oopen_nxt;
    ogain_r <= ogain_nxt;
  end

  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = ov_r;
  assign out_ch.left_out     = olo_r;
  assign out_ch.right_out    = oro_r;
  assign out_ch.is_open      = oopen_r;
  assign out_ch.applied_gain = ogain_r;

endmodule

### rtl/core/stereo_linked_noise_gate.sv
// ----------------------------------------------------------------------------
// Stereo linked noise gate
// Linked-channel gate with envelope follower, hysteresis and gain ramp.
// ----------------------------------------------------------------------------
//   channel  direction  beat contents
//   in_ch    sink       left_in, right_in
//   out_ch   source     left_out, right_out, is_open, applied_gain
//   cfg_ch   sink       index, data (register write, always ready)
//
// The back-end sequencer works on one sample pair at a time, with its single
// shared multiplier forming the envelope, gain, left and right products in turn.
// A two-beat queue lets the front end accept pairs while the back end works.
// A finished result waits in the output register; the sequencer stalls in its
// last step only when that register is still full.
// Synchronous reset restores the registers, unity gain and an open gate.
// ----------------------------------------------------------------------------
module stereo_linked_noise_gate #(
  parameter int SAMPLE_BITS = sng_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = sng_pkg::COEF_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sng_in_if.sink    in_ch,
  sng_out_if.source out_ch,
  sng_cfg_if.sink   cfg_ch
);
  import sng_pkg::*;
  `include "stereo_linked_noise_gate_macros.svh"

  localparam int QW = 3 * SAMPLE_BITS;
  localparam logic [COEF_BITS:0] GAIN_ONE = {1'b1, {COEF_BITS{1'b0}}};

  logic                          f_valid;
  logic                          f_ready;
  logic signed [SAMPLE_BITS-1:0] f_left;
  logic signed [SAMPLE_BITS-1:0] f_right;
  logic [SAMPLE_BITS-1:0]        f_mag;
  logic [QW-1:0]                 f_data;
  logic                          q_valid;
  logic                          q_ready;
  logic [QW-1:0]                 q_data;

  sng_front #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_ch      (in_ch),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_left  (f_left),
    .push_right (f_right),
    .push_mag   (f_mag)
  );

  assign f_data = {f_left, f_right, f_mag};

  sng_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_data  (f_data),
    .m_valid (q_valid),
    .m_ready (q_ready),
    .m_data  (q_data)
  );

  sng_back #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_left  ($signed(q_data[3*SAMPLE_BITS-1:2*SAMPLE_BITS])),
    .q_right ($signed(q_data[2*SAMPLE_BITS-1:SAMPLE_BITS])),
    .q_mag   (q_data[SAMPLE_BITS-1:0]),
    .cfg_ch  (cfg_ch),
    .out_ch  (out_ch)
  );

  `SNG_CHECK(a_gain_range, out_ch.valid |-> out_ch.applied_gain <= GAIN_ONE, "gain above unity")
  `SNG_CHECK(a_mute, (out_ch.valid && out_ch.applied_gain == '0) |-> (out_ch.left_out == '0 && out_ch.right_out == '0), "zero gain passed signal")
  `SNG_CHECK_RESET(a_reset_idle, !rst_n |=> !out_ch.valid, "result offered after reset")

endmodule

### test/stereo_linked_noise_gate_tb.sv
// ----------------------------------------------------------------------------
// Stereo linked noise gate testbench
// Sends sample pairs through the gate in bursts. The gate is run under
// several register settings. Each result beat is checked against a
// bit-exact model of the envelope follower, the hysteresis flag and the
// gain ramp. The receiver stalls at random and twice holds off for a long
// stretch.
// ----------------------------------------------------------------------------
module stereo_linked_noise_gate_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sng_pkg::*;

  localparam int SB = SAMPLE_BITS_DEF;
  localparam int CB = COEF_BITS_DEF;
  localparam longint SMAX = (longint'(1) <<< (SB - 1)) - 1;
  localparam longint SMIN = -(longint'(1) <<< (SB - 1));
  localparam longint UNITY = longint'(1) <<< CB;
  localparam int unsigned FULL_SCALE = 32'd1 << (SB - 1);
  localparam int SETTLE_CYCLES = 30;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
  } pair_t;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 is_open;
    logic [CB:0]          gain;
  } gated_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                          snd_valid = 1'b0;
  logic signed [SB-1:0]          snd_left = '0;
  logic signed [SB-1:0]          snd_right = '0;
  logic                          rcv_ready = 1'b0;
  logic                          wr_valid = 1'b0;
  logic [CFG_INDEX_BITS-1:0]     wr_index = '0;
  logic [CFG_DATA_BITS-1:0]      wr_data = '0;

  sng_in_if  #(.SAMPLE_BITS(SB))                 in_ch ();
  sng_out_if #(.SAMPLE_BITS(SB), .COEF_BITS(CB)) out_ch ();
  sng_cfg_if                                     cfg_ch ();

  assign in_ch.valid    = snd_valid;
  assign in_ch.left_in  = snd_left;
  assign in_ch.right_in = snd_right;
  assign out_ch.ready   = rcv_ready;
  assign cfg_ch.valid   = wr_valid;
  assign cfg_ch.index   = wr_index;
  assign cfg_ch.data    = wr_data;

  stereo_linked_noise_gate #(.SAMPLE_BITS(SB), .COEF_BITS(CB)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Model copy of the registers and the gate state.
  logic [CB-1:0] atk_step  = CB'(ATTACK_STEP_RST);
  logic [CB-1:0] rel_step  = CB'(RELEASE_STEP_RST);
  logic [SB-1:0] open_lvl  = SB'(OPEN_THRESH_RST);
  logic [SB-1:0] close_lvl = SB'(CLOSE_THRESH_RST);
  logic [SB-1:0] env_lvl   = '0;
  logic          gate_open = 1'b1;
  logic [CB:0]   gain_lvl  = (CB+1)'(UNITY);

  pair_t  pair_backlog[$];
  gated_t gated_pending[$];

  int burst_left = 0;
  int gap_left = 0;
  int results_seen = 0;
  int mismatches = 0;
  int hold_left = 0;
  int long_holds = 0;
  int mode_left = 0;
  int rcv_mode = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint round_q16(input longint p);
    longint mag;
    mag = (p < 0) ? -p : p;
    mag = (mag + (longint'(1) <<< (CB - 1))) >>> CB;
    return (p < 0) ? -mag : mag;
  endfunction

  function automatic longint clip_sample(input longint v);
    if (v > SMAX) return SMAX;
    if (v < SMIN) return SMIN;
    return v;
  endfunction

  function automatic gated_t gate_pair(input pair_t s);
    gated_t        res;
    longint        l, r, ml, mr, m, env, gain, tgt;
    logic [CB-1:0] es, gs;
    l = $signed(s.left);
    r = $signed(s.right);
    ml = (l < 0) ? -l : l;
    mr = (r < 0) ? -r : r;
    m = (ml > mr) ? ml : mr;
    env = longint'(env_lvl);
    es = (m > env) ? atk_step : rel_step;
    env = env + round_q16(longint'(es) * (m - env));
    env_lvl = env[SB-1:0];
    if (gate_open) begin
      if (env < longint'(close_lvl)) gate_open = 1'b0;
    end else if (env > longint'(open_lvl)) begin
      gate_open = 1'b1;
    end
    tgt = gate_open ? UNITY : 0;
    gs = gate_open ? atk_step : rel_step;
    gain = longint'(gain_lvl);
    gain = gain + round_q16(longint'(gs) * (tgt - gain));
    gain_lvl = gain[CB:0];
    res.left = clip_sample(round_q16(l * gain)) & ((longint'(1) <<< SB) - 1);
    res.right = clip_sample(round_q16(r * gain)) & ((longint'(1) <<< SB) - 1);
    res.is_open = gate_open;
    res.gain = gain_lvl;
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      snd_valid <= 1'b0;
    end else begin : drive
      pair_t cur;
      pair_t nxt;
      if (snd_valid && in_ch.ready) begin
        cur.left = snd_left;
        cur.right = snd_right;
        gated_pending.push_back(gate_pair(cur));
      end
      if (!snd_valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          snd_valid <= 1'b0;
        end else if (pair_backlog.size() > 0) begin
          nxt = pair_backlog.pop_front();
          snd_left <= nxt.left;
          snd_right <= nxt.right;
          snd_valid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
          end
        end else begin
          snd_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      rcv_ready <= 1'b0;
    end else begin
      if (out_ch.valid && rcv_ready) begin : check
        gated_t want;
        gated_t got;
        got.left = out_ch.left_out;
        got.right = out_ch.right_out;
        got.is_open = out_ch.is_open;
        got.gain = out_ch.applied_gain;
        results_seen++;
        if (gated_pending.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result beat: left %0d right %0d open %0b gain %0d",
                     $signed(got.left), $signed(got.right), got.is_open, got.gain);
        end else begin
          want = gated_pending.pop_front();
          if (got.left !== want.left || got.right !== want.right ||
              got.is_open !== want.is_open || got.gain !== want.gain) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d: expected %0d %0d %0b %0d, got %0d %0d %0b %0d",
                       results_seen, $signed(want.left), $signed(want.right),
                       want.is_open, want.gain, $signed(got.left),
                       $signed(got.right), got.is_open, got.gain);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rcv_ready <= 1'b0;
      end else if ((long_holds == 0 && results_seen >= 300) ||
                   (long_holds == 1 && results_seen >= 900)) begin
        long_holds++;
        hold_left = 250;
        rcv_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          rcv_mode = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end else begin
          mode_left--;
        end
        case (rcv_mode)
          0: rcv_ready <= 1'b1;
          1: rcv_ready <= ($urandom_range(0, 3) != 0);
          default: rcv_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic reg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    wr_valid <= 1'b1;
    wr_index <= idx;
    wr_data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ATTACK_STEP:  atk_step = val[CB-1:0];
      REG_RELEASE_STEP: rel_step = val[CB-1:0];
      REG_OPEN_THRESH:  open_lvl = val[SB-1:0];
      REG_CLOSE_THRESH: close_lvl = val[SB-1:0];
      default: ;
    endcase
    wr_valid <= 1'b0;
  endtask

  task automatic set_gate(input logic [CFG_DATA_BITS-1:0] atk, input logic [CFG_DATA_BITS-1:0] rel,
                          input logic [CFG_DATA_BITS-1:0] op, input logic [CFG_DATA_BITS-1:0] cl);
    reg_write(REG_ATTACK_STEP, atk);
    reg_write(REG_RELEASE_STEP, rel);
    reg_write(REG_OPEN_THRESH, op);
    reg_write(REG_CLOSE_THRESH, cl);
  endtask

  task automatic drain(input int extra);
    while (pair_backlog.size() > 0 || snd_valid || gated_pending.size() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic add_pair(input longint l, input longint r);
    pair_t p;
    p.left = l[SB-1:0];
    p.right = r[SB-1:0];
    pair_backlog.push_back(p);
  endtask

  function automatic longint pick_level(input int unsigned amp);
    longint v;
    if (amp > FULL_SCALE) amp = FULL_SCALE;
    v = $urandom_range(0, amp);
    if ($urandom_range(0, 1)) v = -v;
    return clip_sample(v);
  endfunction

  // Segments of steady loudness open and close the gate; the rest is noise.
  task automatic add_random(input int count);
    int unsigned amp, base;
    int          kind, seg, chunk;
    chunk = 0;
    while (count > 0) begin
      kind = $urandom_range(0, 4);
      seg = $urandom_range(4, 50);
      base = ($urandom_range(0, 1)) ? open_lvl : close_lvl;
      case (kind)
        0: amp = FULL_SCALE;
        1: amp = close_lvl / 2 + 1;
        2: amp = base + base / 8 + 1;
        default: amp = $urandom_range(0, 64);
      endcase
      repeat (seg) begin
        if (count > 0) begin
          if (kind == 3)
            add_pair(longint'($signed(SB'($urandom()))), longint'($signed(SB'($urandom()))));
          else if ($urandom_range(0, 1))
            add_pair(pick_level(amp), pick_level(amp / $urandom_range(1, 8)));
          else
            add_pair(pick_level(amp / $urandom_range(1, 8)), pick_level(amp));
          count--;
          chunk++;
        end
      end
      if (chunk > 120) begin
        drain(0);
        chunk = 0;
      end
    end
  endtask

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(2000, 65535);
      default: return $urandom_range(1, 500);
    endcase
  endfunction

  initial begin : stimulus
    int unsigned op;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    add_pair(0, 0);
    add_pair(SMAX, SMIN);
    add_pair(SMIN, SMAX);
    add_pair(SMIN, SMIN);
    add_pair(SMAX, SMAX);
    add_pair(1, -1);
    add_pair(-1, 0);
    add_random(150);
    drain(SETTLE_CYCLES);

    // Fast steps settle the envelope exactly on the magnitude and on both thresholds.
    set_gate(65535, 65535, 1000, 1000);
    add_pair(1000, 0);
    add_pair(0, -1000);
    add_pair(-1000, 1000);
    add_pair(500, -20);
    add_pair(2000, 0);
    add_pair(2000, 2000);
    add_pair(SMIN, 0);
    add_pair(SMIN, SMIN);
    add_random(150);
    drain(SETTLE_CYCLES);

    set_gate(0, 0, 40000, 30000);
    add_pair(SMAX, SMIN);
    add_pair(0, 0);
    add_pair(SMIN, 5);
    add_random(60);
    drain(SETTLE_CYCLES);

    // Thresholds beyond full scale, with high data bits and stray indexes.
    reg_write($urandom_range(4, (1 << CFG_INDEX_BITS) - 1), $urandom());
    reg_write($urandom_range(4, (1 << CFG_INDEX_BITS) - 1), $urandom());
    set_gate(32'hABCD_0000 | 4000, 32'h5A5A_0000 | 3000, 32'hFFFF_FFFF, 32'hFF80_0001);
    add_pair(SMIN, SMIN);
    add_pair(SMAX, 0);
    add_random(100);
    drain(SETTLE_CYCLES);

    set_gate(pick_step(), pick_step(), 200000, 1500000);
    add_random(150);
    drain(SETTLE_CYCLES);

    set_gate(65535, 65535, 0, 0);
    add_random(80);
    drain(SETTLE_CYCLES);

    set_gate(65535, 0, FULL_SCALE, FULL_SCALE);
    add_random(80);
    drain(SETTLE_CYCLES);

    repeat (3) begin
      op = $urandom_range(0, FULL_SCALE);
      set_gate(pick_step(), pick_step(), op, op / $urandom_range(1, 4));
      add_random(170);
      drain(SETTLE_CYCLES);
    end

    set_gate(ATTACK_STEP_RST, RELEASE_STEP_RST, OPEN_THRESH_RST, CLOSE_THRESH_RST);
    add_random(100);
    drain(SETTLE_CYCLES);

    if (mismatches == 0 && gated_pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
